>>> rtl/core/u8u16_pkg.sv
package u8u16_pkg;

   // Sequence lengths held in the state
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] SUPP_BASE      = 21'h10000;

   // Result queue depth
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [7:0] held0;
      logic [7:0] held1;
      logic [7:0] held2;
      logic [1:0] count;
      logic [2:0] need;
   } u8u16_state_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic        string_end;
   } u8u16_res_type;

   typedef struct packed {
      u8u16_state_type next_state;
      logic [1:0]      res_count;
      u8u16_res_type   res0;
      u8u16_res_type   res1;
   } u8u16_step_type;

endpackage

>>> rtl/core/u8u16_ifs.sv
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        unit_valid;
   logic        string_end;

   modport source (output valid, output code_unit, output unit_valid, output string_end,
                   input ready);
   modport sink   (input valid, input code_unit, input unit_valid, input string_end,
                   output ready);
endinterface

>>> rtl/core/u8u16_decode.sv
module u8u16_decode
   import u8u16_pkg::*;
(
   input  logic            [7:0] byte_value,
   input  logic                  last_byte,
   input  u8u16_state_type       state,
   output u8u16_step_type        step
);

   logic            idle;
   logic            complete;
   logic [20:0]     cp;
   logic [20:0]     cp_off;
   u8u16_state_type post;
   logic [1:0]      n_units;
   logic [15:0]     u0;
   logic [15:0]     u1;

   assign idle     = (state.need == SEQ_NONE);
   assign complete = !idle && (({1'b0, state.count} + 3'd1) >= state.need);

   // Code point of a completed sequence
   always_comb begin
      case (state.need)
         SEQ_LEN2: cp = {10'd0, state.held0[4:0], byte_value[5:0]};
         SEQ_LEN3: cp = {5'd0, state.held0[3:0], state.held1[5:0], byte_value[5:0]};
         default:  cp = {state.held0[2:0], state.held1[5:0], state.held2[5:0],
                         byte_value[5:0]};
      endcase
   end

   assign cp_off = cp - SUPP_BASE;

   // State update, unit collection and the end-of-string rescan
   always_comb begin
      post    = state;
      n_units = 2'd0;
      u0      = 16'd0;
      u1      = 16'd0;

      if (idle) begin
         if (!byte_value[7]) begin
            n_units = 2'd1;
            u0      = {8'd0, byte_value};
         end else if (byte_value[7:5] == 3'b110) begin
            post.need = SEQ_LEN2;
         end else if (byte_value[7:4] == 4'hE) begin
            post.need = SEQ_LEN3;
         end else if (byte_value[7:3] == 5'h1E) begin
            post.need = SEQ_LEN4;
         end
         if (post.need != SEQ_NONE) begin
            post.held0 = byte_value;
            post.count = 2'd1;
         end
      end else if (complete) begin
         if (cp[20:16] != 5'd0) begin
            n_units = 2'd2;
            u0      = HIGH_SURR_BASE + {5'd0, cp_off[20:10]};
            u1      = LOW_SURR_BASE | {6'd0, cp_off[9:0]};
         end else begin
            n_units = 2'd1;
            u0      = cp[15:0];
         end
         post = '0;
      end else begin
         if (state.count == 2'd1) post.held1 = byte_value;
         else                     post.held2 = byte_value;
         post.count = state.count + 2'd1;
      end

      // String ends inside a sequence: drop the lead, rescan the rest
      if (last_byte && (post.need != SEQ_NONE)) begin
         if (post.count == 2'd2) begin
            if (!post.held1[7]) begin
               n_units = 2'd1;
               u0      = {8'd0, post.held1};
            end
         end else if (post.count == 2'd3) begin
            if (!post.held1[7]) begin
               n_units = 2'd1;
               u0      = {8'd0, post.held1};
               if (!post.held2[7]) begin
                  n_units = 2'd2;
                  u1      = {8'd0, post.held2};
               end
            end else if (post.held1[7:5] == 3'b110) begin
               n_units = 2'd1;
               u0      = {5'd0, post.held1[4:0], post.held2[5:0]};
            end else if (!post.held2[7]) begin
               n_units = 2'd1;
               u0      = {8'd0, post.held2};
            end
         end
         post = '0;
      end
   end

   // Result items
   always_comb begin
      step.next_state = post;
      if (last_byte && (n_units == 2'd0)) begin
         step.res_count = 2'd1;
         step.res0      = '{code_unit: 16'd0, unit_valid: 1'b0, string_end: 1'b1};
         step.res1      = '0;
      end else begin
         step.res_count = n_units;
         step.res0      = '{code_unit: u0, unit_valid: 1'b1,
                            string_end: last_byte && (n_units == 2'd1)};
         step.res1      = '{code_unit: u1, unit_valid: 1'b1, string_end: last_byte};
      end
   end

endmodule

>>> rtl/core/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 decoder core.
// Each byte is held in the input register, decoded, and its items written to the result queue.
// Throughput: one byte per cycle while the queue has room; a surrogate pair adds two items,
// which the 4-entry result queue absorbs; input stalls while it holds more than two items.
// Reset (synchronous, active high) empties the input register and result
// queue and drops any partly received sequence.
module utf8_to_utf16_decoder_core
   import u8u16_pkg::*;
(
   input  logic clock,
   input  logic reset,
   u8u16_req_if.sink   req_if,
   u8u16_rsp_if.source rsp_if
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   u8u16_state_type      state_ff;
   u8u16_step_type       step;
   logic                 fire;
   logic                 push;
   logic                 pop;

   u8u16_res_type        rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W:0]   cnt_ff;
   logic [RSP_PTR_W:0]   cnt_in;

   // Decode fires when the queue has room for two items
   assign fire          = in_valid_ff && (cnt_ff <= (RSP_PTR_W + 1)'(RSP_DEPTH - 2));
   assign req_if.ready  = !in_valid_ff || fire;
   assign push          = fire && (step.res_count != 2'd0);
   assign pop           = rsp_if.valid && rsp_if.ready;

   u8u16_decode u_decode (
      .byte_value (in_byte_ff),
      .last_byte  (in_last_ff),
      .state      (state_ff),
      .step       (step)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.byte_value;
         in_last_ff <= req_if.last_byte;
      end
   end

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= step.next_state;
      end
   end

   // Result queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(step.res_count);
         cnt_in    = cnt_ff + (RSP_PTR_W + 1)'(step.res_count);
      end
      if (pop) begin
         cnt_in = cnt_in - (RSP_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
      if (push) begin
         rsp_mem_ff[wr_ptr_ff] <= step.res0;
         if (step.res_count == 2'd2) begin
            rsp_mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= step.res1;
         end
      end
   end

   assign rsp_if.valid      = (cnt_ff != '0);
   assign rsp_if.code_unit  = rsp_mem_ff[rd_ptr_ff].code_unit;
   assign rsp_if.unit_valid = rsp_mem_ff[rd_ptr_ff].unit_valid;
   assign rsp_if.string_end = rsp_mem_ff[rd_ptr_ff].string_end;

endmodule

>>> rtl/core/u8u16_checker.sv
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_unit_valid,
   input logic        rsp_string_end
);

   // A stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item withdrawn while stalled");

   // An empty item is only the end-of-string marker, with a zero unit
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_unit_valid |-> rsp_string_end && (rsp_code_unit == 16'd0))
      else $error("empty result item is not a clean end marker");

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item offered right after reset");

   // Reset empties the input register
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

endmodule

bind utf8_to_utf16_decoder_core u8u16_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_code_unit  (rsp_if.code_unit),
   .rsp_unit_valid (rsp_if.unit_valid),
   .rsp_string_end (rsp_if.string_end)
);
